@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, masked while reset is low.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/bnms_pkg.sv @@
// ----------------------------------------------------------------------------
// bnms_pkg
// Types, constants and helpers shared by the box suppression unit.
// ----------------------------------------------------------------------------
package bnms_pkg;

  localparam int MAX_KEPT    = 64;
  localparam int COORD_BITS  = 16;
  localparam int KADDR_BITS  = $clog2(MAX_KEPT);
  localparam int KCNT_BITS   = 7;
  localparam int IDX_BITS    = 14;
  localparam int THR_BITS    = 9;
  localparam int CLUS_BITS   = 4;
  localparam int EDGE_BITS   = COORD_BITS + 2;
  localparam int AREA_BITS   = 2 * EDGE_BITS + 2;
  localparam int PROD_BITS   = AREA_BITS + THR_BITS + 2;

  localparam logic [IDX_BITS-1:0]  IDX_MAX       = '1;
  localparam logic [THR_BITS-1:0]  THR_RESET     = 9'd128;
  localparam logic [CLUS_BITS-1:0] CLUS_RESET    = 4'd2;

  localparam logic CFG_IOU_THRESHOLD    = 1'b0;
  localparam logic CFG_KEEP_PER_CLUSTER = 1'b1;

  typedef struct packed {
    logic                         frame_start;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic signed [COORD_BITS-1:0] box_width;
    logic signed [COORD_BITS-1:0] box_height;
  } in_word_t;

  typedef struct packed {
    logic                 keep;
    logic [IDX_BITS-1:0]  item_index;
    logic [KCNT_BITS-1:0] kept_total;
    logic                 store_full;
  } out_word_t;

  // Box as edges in doubled units.
  typedef struct packed {
    logic signed [EDGE_BITS-1:0] x1;
    logic signed [EDGE_BITS-1:0] x2;
    logic signed [EDGE_BITS-1:0] y1;
    logic signed [EDGE_BITS-1:0] y2;
  } edge_box_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DECIDE,
    ST_OUT
  } seq_state_t;

  function automatic edge_box_t to_edges(input in_word_t w);
    edge_box_t e;
    logic signed [EDGE_BITS-1:0] cx2, cy2, bw, bh;
    cx2  = EDGE_BITS'(w.center_x) <<< 1;
    cy2  = EDGE_BITS'(w.center_y) <<< 1;
    bw   = EDGE_BITS'(w.box_width);
    bh   = EDGE_BITS'(w.box_height);
    e.x1 = cx2 - bw;
    e.x2 = cx2 + bw;
    e.y1 = cy2 - bh;
    e.y2 = cy2 + bh;
    return e;
  endfunction

endpackage

@@ hdl/bnms_iou.sv @@
// ----------------------------------------------------------------------------
// bnms_iou
// Three-stage overlap test of a new box against one stored box.
// ----------------------------------------------------------------------------
module bnms_iou (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  bnms_pkg::edge_box_t            box_a,
  input  bnms_pkg::edge_box_t            box_b,
  input  logic [bnms_pkg::THR_BITS-1:0]  thr,
  output logic                           done,
  output logic                           hit
);

  localparam int EB = bnms_pkg::EDGE_BITS;
  localparam int AB = bnms_pkg::AREA_BITS;
  localparam int PB = bnms_pkg::PROD_BITS;

  logic                 v1_r, v2_r, v3_r;
  logic signed [EB:0]   iw_r, ih_r, aw_r, ah_r, bw_r, bh_r;
  logic signed [AB-1:0] inter_r, uni_r;
  logic                 hit_r;

  logic signed [EB-1:0] ix1, ix2, iy1, iy2;
  logic signed [EB:0]   dx, dy;
  logic signed [AB-1:0] inter_w, area_a, area_b;
  logic signed [PB-1:0] lhs, rhs;

  always_comb begin
    ix1 = (box_a.x1 > box_b.x1) ? box_a.x1 : box_b.x1;
    ix2 = (box_a.x2 < box_b.x2) ? box_a.x2 : box_b.x2;
    iy1 = (box_a.y1 > box_b.y1) ? box_a.y1 : box_b.y1;
    iy2 = (box_a.y2 < box_b.y2) ? box_a.y2 : box_b.y2;
    dx  = (EB+1)'(ix2) - (EB+1)'(ix1);
    dy  = (EB+1)'(iy2) - (EB+1)'(iy1);
    inter_w = AB'(iw_r) * AB'(ih_r);
    area_a  = AB'(aw_r) * AB'(ah_r);
    area_b  = AB'(bw_r) * AB'(bh_r);
    lhs = PB'(inter_r) <<< 8;
    rhs = PB'(uni_r) * PB'($signed({1'b0, thr}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    iw_r <= (dx > 0) ? dx : '0;
    ih_r <= (dy > 0) ? dy : '0;
    aw_r <= (EB+1)'(box_a.x2) - (EB+1)'(box_a.x1);
    ah_r <= (EB+1)'(box_a.y2) - (EB+1)'(box_a.y1);
    bw_r <= (EB+1)'(box_b.x2) - (EB+1)'(box_b.x1);
    bh_r <= (EB+1)'(box_b.y2) - (EB+1)'(box_b.y1);
    inter_r <= inter_w;
    uni_r   <= area_a + area_b - inter_w;
    hit_r   <= (uni_r > 0) && (lhs > rhs);
  end

  assign done = v3_r;
  assign hit  = hit_r;

endmodule

@@ hdl/box_nms_top_k_per_cluster_unit.sv @@
// ----------------------------------------------------------------------------
// box_nms_top_k_per_cluster_unit
// Relaxed greedy non-maximum suppression over a store of kept boxes.
// ----------------------------------------------------------------------------
// Boxes of a frame arrive on the in_ channel sorted by descending score, one
// word per box. A word with frame_start set empties the store and restarts
// the item index before the box is handled. Each box is compared with every
// box kept so far; the store is a 64-entry synchronous memory read one entry
// per cycle into a three-stage overlap pipeline. If fewer than
// keep_per_cluster stored boxes overlap it, the box is written into the store,
// or store_full is set when the store is full. Every box gives exactly one
// result word on the out_ channel. One box is processed at a time and the
// memory read port sets the pace of one comparison a cycle. The next box can
// be accepted in the cycle the previous result is first offered, unless that
// result is stalled. Reset clears the counters and restores the registers
// (threshold 128/256, two per cluster); the store needs no clearing since
// only entries below the kept count are ever read. While a valid result is
// stalled by out_stall, the result word holds and the block takes no new box.
// Configuration writes are accepted at any time and should be made only when
// the block is idle.
module box_nms_top_k_per_cluster_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bnms_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bnms_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam int KA = bnms_pkg::KADDR_BITS;
  localparam int KC = bnms_pkg::KCNT_BITS;

  bnms_pkg::edge_box_t kept_mem [bnms_pkg::MAX_KEPT];
  bnms_pkg::edge_box_t rd_box_r;

  bnms_pkg::seq_state_t state_r, state_nxt;
  logic [bnms_pkg::THR_BITS-1:0]  thr_r;
  logic [bnms_pkg::CLUS_BITS-1:0] clus_r;
  logic [KC-1:0]                  kcnt_r, kcnt_nxt;
  logic [bnms_pkg::IDX_BITS-1:0]  icnt_r, icnt_nxt;
  logic [KC-1:0]                  rd_ptr_r, rd_ptr_nxt;
  logic [KC-1:0]                  same_r, same_nxt;
  bnms_pkg::edge_box_t            nb_r, nb_nxt;
  logic                           rd_en, pend_r, pend_nxt;
  logic [KC-1:0]                  issued_r, issued_nxt, done_cnt_r, done_cnt_nxt;
  logic                           wr_en;
  logic                           out_v_r, out_v_nxt;
  bnms_pkg::out_word_t            out_r, out_nxt;
  bnms_pkg::out_word_t            res_r;
  logic                           cmp_done, cmp_hit;
  logic                           acc;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != bnms_pkg::ST_IDLE) || (out_v_r && out_stall);
  assign acc       = in_valid && !in_stall;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= bnms_pkg::THR_RESET;
      clus_r <= bnms_pkg::CLUS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bnms_pkg::CFG_IOU_THRESHOLD:    thr_r  <= cfg_data[bnms_pkg::THR_BITS-1:0];
        bnms_pkg::CFG_KEEP_PER_CLUSTER: clus_r <= cfg_data[bnms_pkg::CLUS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Store memory: one read port, one write port.
  always_ff @(posedge clk) begin
    if (rd_en) rd_box_r <= kept_mem[rd_ptr_r[KA-1:0]];
    if (wr_en) kept_mem[kcnt_r[KA-1:0]] <= nb_r;
  end

  bnms_iou u_iou (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pend_r),
    .box_a (nb_r),
    .box_b (rd_box_r),
    .thr   (thr_r),
    .done  (cmp_done),
    .hit   (cmp_hit)
  );

  always_comb begin
    state_nxt    = state_r;
    kcnt_nxt     = kcnt_r;
    icnt_nxt     = icnt_r;
    rd_ptr_nxt   = rd_ptr_r;
    same_nxt     = same_r;
    nb_nxt       = nb_r;
    issued_nxt   = issued_r;
    done_cnt_nxt = done_cnt_r;
    out_v_nxt    = out_v_r && out_stall;
    out_nxt      = out_r;
    rd_en        = 1'b0;
    pend_nxt     = 1'b0;
    wr_en        = 1'b0;
    if (cmp_done) begin
      done_cnt_nxt = done_cnt_r + 1'b1;
      if (cmp_hit) same_nxt = same_r + 1'b1;
    end
    unique case (state_r)
      bnms_pkg::ST_IDLE: begin
        if (acc) begin
          nb_nxt       = bnms_pkg::to_edges(in_data);
          same_nxt     = '0;
          rd_ptr_nxt   = '0;
          issued_nxt   = '0;
          done_cnt_nxt = '0;
          if (in_data.frame_start) begin
            kcnt_nxt = '0;
            icnt_nxt = '0;
          end
          state_nxt = bnms_pkg::ST_READ;
        end
      end
      bnms_pkg::ST_READ: begin
        if (rd_ptr_r < kcnt_r) begin
          rd_en      = 1'b1;
          pend_nxt   = 1'b1;
          rd_ptr_nxt = rd_ptr_r + 1'b1;
          issued_nxt = issued_r + 1'b1;
        end else begin
          state_nxt = bnms_pkg::ST_CMP;
        end
      end
      bnms_pkg::ST_CMP: begin
        if (done_cnt_nxt == issued_r) state_nxt = bnms_pkg::ST_DECIDE;
      end
      bnms_pkg::ST_DECIDE: begin
        out_nxt.keep       = 1'b0;
        out_nxt.store_full = 1'b0;
        out_nxt.item_index = icnt_r;
        if (same_r < KC'(clus_r)) begin
          if (kcnt_r < KC'(bnms_pkg::MAX_KEPT)) begin
            wr_en        = 1'b1;
            kcnt_nxt     = kcnt_r + 1'b1;
            out_nxt.keep = 1'b1;
          end else begin
            out_nxt.store_full = 1'b1;
          end
        end
        out_nxt.kept_total = kcnt_nxt;
        if (icnt_r != bnms_pkg::IDX_MAX) icnt_nxt = icnt_r + 1'b1;
        state_nxt = bnms_pkg::ST_OUT;
      end
      bnms_pkg::ST_OUT: begin
        if (!(out_v_r && out_stall)) begin
          out_v_nxt = 1'b1;
          state_nxt = bnms_pkg::ST_IDLE;
        end else begin
          out_v_nxt = 1'b1;
        end
      end
      default: state_nxt = bnms_pkg::ST_IDLE;
    endcase
  end

  // The decided word is parked in out_r only once the output is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bnms_pkg::ST_IDLE;
      kcnt_r   <= '0;
      icnt_r   <= '0;
      out_v_r  <= 1'b0;
      pend_r   <= 1'b0;
      same_r   <= '0;
      issued_r <= '0;
      done_cnt_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      state_r  <= state_nxt;
      kcnt_r   <= kcnt_nxt;
      icnt_r   <= icnt_nxt;
      out_v_r  <= out_v_nxt;
      pend_r   <= pend_nxt;
      same_r   <= same_nxt;
      issued_r <= issued_nxt;
      done_cnt_r <= done_cnt_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
    nb_r <= nb_nxt;
    if (state_r == bnms_pkg::ST_DECIDE) res_r <= out_nxt;
    if (state_r == bnms_pkg::ST_OUT && !(out_v_r && out_stall)) out_r <= res_r;
  end

endmodule

@@ hdl/bnms_checker.sv @@
// ----------------------------------------------------------------------------
// bnms_checker
// Port-level checks of the suppression unit, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bnms_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input bnms_pkg::out_word_t out_data
);

  `CHK_IMPLY(a_keep_full_excl, clk, rst_n, out_valid, !(out_data.keep && out_data.store_full), "keep and store_full both set")
  `CHK_IMPLY(a_total_range, clk, rst_n, out_valid, out_data.kept_total <= 7'(bnms_pkg::MAX_KEPT), "kept_total above store size")
  `CHK_IMPLY(a_keep_nonzero, clk, rst_n, out_valid && out_data.keep, out_data.kept_total != '0, "kept box with zero total")
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `CHK_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "second word taken while busy")

endmodule

bind box_nms_top_k_per_cluster_unit bnms_checker u_bnms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
